// ===== src/stream_find_and_replace_macros.svh =====
// assertion macros for the checker file of the find-and-replace block
// no dependencies
`ifndef STREAM_FIND_AND_REPLACE_MACROS_SVH
`define STREAM_FIND_AND_REPLACE_MACROS_SVH

// same-cycle implication, reset-gated
`define SFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset-gated
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sfr_pkg.sv =====
// shared types and constants for the streaming find-and-replace block
// no dependencies
package sfr_pkg;

	localparam int BYTE_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 5;
	localparam int STR_BYTES  = 16;
	localparam int HALF_BYTES = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VICTIM_LO = 3'd0,
		CFG_VICTIM_HI = 3'd1,
		CFG_VICTIM_LEN = 3'd2,
		CFG_REPL_LO = 3'd3,
		CFG_REPL_HI = 3'd4,
		CFG_REPL_LEN = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_REPL,
		ST_FLUSH,
		ST_MARK
	} state_t;

	typedef enum logic [1:0] {
		SEL_WINDOW,
		SEL_REPL,
		SEL_MARKER
	} out_sel_t;

	typedef struct packed {
		logic     append;
		logic     drop;
		logic     clear_count;
		logic     ridx_clear;
		logic     ridx_inc;
		logic     load;
		out_sel_t out_sel;
		logic     run_last;
		logic     chunk_end;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic count_one;
		logic full_len;
		logic match0;
		logic match1;
		logic rlen_zero;
		logic ridx_last;
		logic out_free;
	} sts_t;

endpackage

// ===== src/sfr_in_if.sv =====
// body byte channel: valid/ready plus one byte and its chunk-end mark
// depends on sfr_pkg
interface sfr_in_if;
	import sfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;
	logic              in_chunk_end;

	modport source(output valid, in_byte, in_chunk_end, input ready);
	modport sink(input valid, in_byte, in_chunk_end, output ready);
endinterface

// ===== src/sfr_out_if.sv =====
// result channel: valid/ready plus emitted byte and its marks
// depends on sfr_pkg
interface sfr_out_if;
	import sfr_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              byte_present;
	logic              run_last;
	logic              out_chunk_end;

	modport source(output valid, out_byte, byte_present, run_last, out_chunk_end,
		input ready);
	modport sink(input valid, out_byte, byte_present, run_last, out_chunk_end,
		output ready);
endinterface

// ===== src/sfr_cfg_if.sv =====
// configuration write channel: valid/ready plus register index and data
// depends on sfr_pkg
interface sfr_cfg_if;
	import sfr_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== src/sfr_ctrl.sv =====
// controller fsm: walks the pending window one comparison per cycle while the output register is not stalled
// depends on sfr_pkg; drives commands to sfr_datapath and reads its status
module sfr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          body_valid,
	input  logic          body_chunk_end,
	output logic          body_ready,
	output logic          cfg_ready,
	input  sfr_pkg::sts_t sts,
	output sfr_pkg::cmd_t cmd
);
	import sfr_pkg::*;

	state_t state_q, state_d;
	logic   chunk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chunk_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && body_valid) begin
				chunk_q <= body_chunk_end;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = SEL_WINDOW;
		body_ready  = 1'b0;
		cfg_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				body_ready = 1'b1;
				cfg_ready  = 1'b1;
				if (body_valid) begin
					cmd.append = 1'b1;
					state_d    = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.count_zero) begin
					state_d = ST_IDLE;
				end else if (sts.full_len && sts.match0) begin
					// whole victim matched, window empties
					cmd.clear_count = 1'b1;
					cmd.ridx_clear  = 1'b1;
					if (!sts.rlen_zero) begin
						state_d = ST_REPL;
					end else if (chunk_q) begin
						state_d = ST_MARK;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (sts.match0) begin
					// window is a proper prefix: keep it, or flush it at chunk end
					state_d = chunk_q ? ST_FLUSH : ST_IDLE;
				end else if (sts.out_free) begin
					// front byte cannot start a match; look one ahead for run_last
					cmd.load      = 1'b1;
					cmd.drop      = 1'b1;
					cmd.out_sel   = SEL_WINDOW;
					cmd.run_last  = sts.count_one || (!chunk_q && sts.match1);
					cmd.chunk_end = chunk_q && sts.count_one;
				end
			end
			ST_REPL: begin
				if (sts.out_free) begin
					cmd.load      = 1'b1;
					cmd.ridx_inc  = 1'b1;
					cmd.out_sel   = SEL_REPL;
					cmd.run_last  = sts.ridx_last;
					cmd.chunk_end = sts.ridx_last && chunk_q;
					if (sts.ridx_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.load      = 1'b1;
					cmd.drop      = 1'b1;
					cmd.out_sel   = SEL_WINDOW;
					cmd.run_last  = sts.count_one;
					cmd.chunk_end = sts.count_one;
					if (sts.count_one) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				if (sts.out_free) begin
					cmd.load      = 1'b1;
					cmd.out_sel   = SEL_MARKER;
					cmd.run_last  = 1'b1;
					cmd.chunk_end = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/sfr_datapath.sv =====
// datapath: configuration registers, pending window shift register,
// prefix comparators, replacement index and output register
// depends on sfr_pkg and sfr_out_if; commanded by sfr_ctrl
module sfr_datapath #(
	parameter int MAX_VICTIM_LEN      = 16,
	parameter int MAX_REPLACEMENT_LEN = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [sfr_pkg::BYTE_W-1:0]     body_byte,
	input  sfr_pkg::cmd_t                  cmd,
	output sfr_pkg::sts_t                  sts,
	sfr_out_if.source                      result
);
	import sfr_pkg::*;

	localparam int W   = MAX_VICTIM_LEN;
	localparam int CW  = $clog2(W + 1);
	localparam int RIW = (MAX_REPLACEMENT_LEN > 1) ? $clog2(MAX_REPLACEMENT_LEN) : 1;

	logic [CFG_DATA_W-1:0] victim_lo_q, victim_hi_q, repl_lo_q, repl_hi_q;
	logic [LEN_W-1:0]      vlen_raw_q, rlen_raw_q;

	logic [BYTE_W-1:0] window_q [W];
	logic [CW-1:0]     count_q;
	logic [RIW-1:0]    ridx_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              present_q, run_last_q, chunk_end_q;

	logic [BYTE_W-1:0] vic_b [STR_BYTES];
	logic [BYTE_W-1:0] rep_b [STR_BYTES];
	logic [CW-1:0]     vlen_eff;
	logic [LEN_W-1:0]  rlen_eff;
	logic [CW-1:0]     append_pos;
	logic [W-1:0]      ok0, ok1;
	logic              cfg_hit;

	always_comb begin
		for (int i = 0; i < HALF_BYTES; i++) begin
			vic_b[i]              = victim_lo_q[i*BYTE_W +: BYTE_W];
			vic_b[i + HALF_BYTES] = victim_hi_q[i*BYTE_W +: BYTE_W];
			rep_b[i]              = repl_lo_q[i*BYTE_W +: BYTE_W];
			rep_b[i + HALF_BYTES] = repl_hi_q[i*BYTE_W +: BYTE_W];
		end
	end

	// zero victim length counts as one, long lengths saturate
	always_comb begin
		if (vlen_raw_q == '0) begin
			vlen_eff = CW'(1);
		end else if (vlen_raw_q > LEN_W'(W)) begin
			vlen_eff = CW'(W);
		end else begin
			vlen_eff = CW'(vlen_raw_q);
		end
		rlen_eff = (rlen_raw_q > LEN_W'(MAX_REPLACEMENT_LEN)) ?
			LEN_W'(MAX_REPLACEMENT_LEN) : rlen_raw_q;
		append_pos = (count_q >= vlen_eff) ? '0 : count_q;
	end

	// window vs victim prefix, and window shifted by one vs victim prefix
	always_comb begin
		ok1 = '1;
		for (int i = 0; i < W; i++) begin
			ok0[i] = (window_q[i] == vic_b[i]) || (CW'(i) >= count_q);
		end
		for (int i = 0; i < W - 1; i++) begin
			ok1[i] = (window_q[i+1] == vic_b[i]) || (CW'(i + 1) >= count_q);
		end
	end

	always_comb begin
		sts.count_zero = (count_q == '0);
		sts.count_one  = (count_q == CW'(1));
		sts.full_len   = (count_q == vlen_eff);
		sts.match0     = &ok0;
		sts.match1     = &ok1;
		sts.rlen_zero  = (rlen_eff == '0);
		sts.ridx_last  = ((LEN_W'(ridx_q) + LEN_W'(1)) == rlen_eff);
		sts.out_free   = !out_valid_q || result.ready;
	end

	always_comb begin
		case (cfg_index)
			CFG_VICTIM_LO, CFG_VICTIM_HI, CFG_VICTIM_LEN,
			CFG_REPL_LO, CFG_REPL_HI, CFG_REPL_LEN: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_lo_q <= '0;
			victim_hi_q <= '0;
			vlen_raw_q  <= LEN_W'(1);
			repl_lo_q   <= '0;
			repl_hi_q   <= '0;
			rlen_raw_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VICTIM_LO:  victim_lo_q <= cfg_data;
				CFG_VICTIM_HI:  victim_hi_q <= cfg_data;
				CFG_VICTIM_LEN: vlen_raw_q  <= cfg_data[LEN_W-1:0];
				CFG_REPL_LO:    repl_lo_q   <= cfg_data;
				CFG_REPL_HI:    repl_hi_q   <= cfg_data;
				CFG_REPL_LEN:   rlen_raw_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			for (int i = 0; i < W; i++) begin
				if (CW'(i) == append_pos) begin
					window_q[i] <= body_byte;
				end
			end
		end else if (cmd.drop) begin
			for (int i = 0; i < W - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ridx_q  <= '0;
		end else begin
			// a write to any mapped register drops the pending bytes
			if (cfg_hit || cmd.clear_count) begin
				count_q <= '0;
			end else if (cmd.append) begin
				count_q <= append_pos + CW'(1);
			end else if (cmd.drop) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.ridx_clear) begin
				ridx_q <= '0;
			end else if (cmd.ridx_inc) begin
				ridx_q <= ridx_q + RIW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			run_last_q  <= cmd.run_last;
			chunk_end_q <= cmd.chunk_end;
			case (cmd.out_sel)
				SEL_WINDOW: begin
					out_byte_q <= window_q[0];
					present_q  <= 1'b1;
				end
				SEL_REPL: begin
					out_byte_q <= rep_b[4'(ridx_q)];
					present_q  <= 1'b1;
				end
				default: begin
					out_byte_q <= '0;
					present_q  <= 1'b0;
				end
			endcase
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_byte      = out_byte_q;
	assign result.byte_present  = present_q;
	assign result.run_last      = run_last_q;
	assign result.out_chunk_end = chunk_end_q;

endmodule

// ===== src/stream_find_and_replace.sv =====
// a new item is accepted only after every result of the previous one has been loaded into
// the output register; the scan loop does one window-against-victim comparison per cycle and
// loads results one per cycle, both only while the output register is not stalled
// a byte passed through is loaded from the scan state; a replacement, a chunk-end flush or an
// end marker is loaded from its own state after the scan state; single output register
// reset (arst_n low): controller idle, window empty, registers at their reset values
module stream_find_and_replace #(
	parameter int MAX_VICTIM_LEN      = 16,
	parameter int MAX_REPLACEMENT_LEN = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_in_if.sink    body,
	sfr_out_if.source result,
	sfr_cfg_if.sink   cfg
);
	import sfr_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic cfg_ready;

	assign cfg.ready = cfg_ready;

	sfr_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.body_valid     (body.valid),
		.body_chunk_end (body.in_chunk_end),
		.body_ready     (body.ready),
		.cfg_ready      (cfg_ready),
		.sts            (sts),
		.cmd            (cmd)
	);

	sfr_datapath #(
		.MAX_VICTIM_LEN      (MAX_VICTIM_LEN),
		.MAX_REPLACEMENT_LEN (MAX_REPLACEMENT_LEN)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg.valid && cfg_ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.body_byte (body.in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

// ===== src/sfr_checker.sv =====
// port-level checks of the find-and-replace block, bound to its top level
// depends on stream_find_and_replace_macros.svh
`include "stream_find_and_replace_macros.svh"

module sfr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       body_valid,
	input logic       body_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] result_out_byte,
	input logic       result_byte_present,
	input logic       result_run_last,
	input logic       result_out_chunk_end
);

	// chunk end always closes the run of its byte
	`SFR_ASSERT_NOW(a_chunk_end_is_last, clk, arst_n, result_valid && result_out_chunk_end, result_run_last, "chunk end without run_last")

	// a bare marker only ever ends a chunk and carries a zero byte
	`SFR_ASSERT_NOW(a_marker_form, clk, arst_n, result_valid && !result_byte_present, result_out_chunk_end && result_run_last && (result_out_byte == 8'd0), "malformed end marker")

	// more results of the same byte still to come, so no new body transaction
	`SFR_ASSERT_NOW(a_no_take_mid_run, clk, arst_n, result_valid && !result_run_last, !body_ready, "body ready in the middle of a run")

	// one body byte at a time
	`SFR_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, body_valid && body_ready, !body_ready, "body ready right after a transaction")

	// a stalled result holds
	`SFR_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_out_byte) && $stable(result_run_last), "stalled result changed")

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.body_valid           (body.valid),
	.body_ready           (body.ready),
	.result_valid         (result.valid),
	.result_ready         (result.ready),
	.result_out_byte      (result.out_byte),
	.result_byte_present  (result.byte_present),
	.result_run_last      (result.run_last),
	.result_out_chunk_end (result.out_chunk_end)
);

// ===== sim/tb.sv =====
// self-checking testbench for stream_find_and_replace: directed table, then random phases
// depends on sfr_pkg, sfr_in_if, sfr_out_if, sfr_cfg_if and the block itself
module tb;
	import sfr_pkg::*;

	localparam int ITEMS_PER_PHASE = 33;
	localparam int N_PHASES        = 8;
	localparam int STALL_PHASE     = 3;
	localparam int PAUSE_PHASE     = 5;
	localparam int LONG_STALL      = 300;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 16;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int MAX_RESULTS     = 16;
	localparam int N_DIRECTED      = 33;

	// indexes with no register behind them; NO_REG is index zero, carried unused by byte rows
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE_HI = 3'd7;
	localparam logic [CFG_IDX_W-1:0] NO_REG      = '0;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              byte_present;
		logic              run_last;
		logic              out_chunk_end;
	} result_t;

	typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;  // register data, or the body byte in bits 7:0
		logic                  chunk_end;
		logic                  typed;
		result_t               want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sfr_in_if  body_bus();
	sfr_out_if result_bus();
	sfr_cfg_if cfg_bus();

	stream_find_and_replace i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.body  (body_bus),
		.result(result_bus),
		.cfg   (cfg_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// shadow copy of the block's registers and pending window
	logic [CFG_DATA_W-1:0] victim_lo, victim_hi, repl_lo, repl_hi;
	logic [LEN_W-1:0]      victim_len_reg, repl_len_reg;
	logic [BYTE_W-1:0]     window [STR_BYTES];
	int                    window_count;

	result_t step_results[$];
	result_t awaited_results[$];
	int      mismatches = 0;
	int      sender_idle_pct = 20;
	int      sink_idle_pct = 20;
	bit      long_stall_req = 1'b0;

	stim_row_t directed_rows [N_DIRECTED] = '{
		// after reset: victim is one zero byte, replacement empty
		'{ROW_BYTE, NO_REG, 64'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b1}},
		'{ROW_BYTE, NO_REG, 64'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
		// "abc" -> "XYZW", overlapping start and a partial match flushed at chunk end
		'{ROW_REG, CFG_VICTIM_LO, 64'h636261, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_VICTIM_LEN, 64'd3, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LO, 64'h575A5958, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LEN, 64'd4, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_NONE_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h61, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h61, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h62, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h63, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h61, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h62, 1'b1, 1'b0, '0},
		// zero victim length acts as one, oversized replacement length saturates
		'{ROW_REG, CFG_VICTIM_LO, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_VICTIM_LEN, 64'd0, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LO, 64'h8877_6655_4433_2211, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_HI, 64'h00FF_EEDD_CCBB_AA99, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LEN, 64'd31, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b1, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
		// deletion; an unmapped write keeps the window, a real write empties it
		'{ROW_REG, CFG_VICTIM_LEN, 64'd2, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LEN, 64'd0, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_NONE_HI, 64'd0, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_REPL_LEN, 64'd1, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'h41, 1'b1, 1'b1, '{8'h41, 1'b1, 1'b1, 1'b1}},
		// oversized victim length saturates at sixteen
		'{ROW_REG, CFG_VICTIM_HI, 64'h01, 1'b0, 1'b0, '0},
		'{ROW_REG, CFG_VICTIM_LEN, 64'd17, 1'b0, 1'b0, '0},
		'{ROW_BYTE, NO_REG, 64'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1}}
	};

	function automatic logic [BYTE_W-1:0] string_byte(input logic [CFG_DATA_W-1:0] lo,
		input logic [CFG_DATA_W-1:0] hi, input int i);
		logic [CFG_DATA_W-1:0] word;
		word = (i < HALF_BYTES) ? lo : hi;
		return word[8*(i % HALF_BYTES) +: 8];
	endfunction

	function automatic bit window_matches(input int n);
		for (int i = 0; i < n; i++) begin
			if (window[i] != string_byte(victim_lo, victim_hi, i))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void drop_front(input int k);
		if (k >= window_count) begin
			window_count = 0;
			return;
		end
		for (int i = 0; i + k < window_count; i++)
			window[i] = window[i + k];
		window_count -= k;
	endfunction

	function automatic void add_result(input logic [BYTE_W-1:0] b, input logic present);
		if (step_results.size() < MAX_RESULTS)
			step_results.push_back('{b, present, 1'b0, 1'b0});
	endfunction

	function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_VICTIM_LO:  victim_lo = val;
			CFG_VICTIM_HI:  victim_hi = val;
			CFG_VICTIM_LEN: victim_len_reg = val[LEN_W-1:0];
			CFG_REPL_LO:    repl_lo = val;
			CFG_REPL_HI:    repl_hi = val;
			CFG_REPL_LEN:   repl_len_reg = val[LEN_W-1:0];
			default:        return;
		endcase
		window_count = 0;
	endfunction

	// results one body byte causes, left in step_results
	function automatic void rewrite_byte(input logic [BYTE_W-1:0] b, input logic ce);
		int      vlen;
		int      rlen;
		result_t tail;
		step_results.delete();
		vlen = (victim_len_reg == 0) ? 1 :
			(victim_len_reg > STR_BYTES) ? STR_BYTES : int'(victim_len_reg);
		rlen = (repl_len_reg > STR_BYTES) ? STR_BYTES : int'(repl_len_reg);
		if (window_count >= vlen)
			window_count = 0;
		window[window_count] = b;
		window_count++;
		while (window_count != 0) begin
			if (window_count >= vlen && window_matches(vlen)) begin
				for (int i = 0; i < rlen; i++)
					add_result(string_byte(repl_lo, repl_hi, i), 1'b1);
				drop_front(vlen);
			end else if (window_count < vlen && window_matches(window_count)) begin
				break;
			end else begin
				add_result(window[0], 1'b1);
				drop_front(1);
			end
		end
		if (ce) begin
			for (int i = 0; i < window_count; i++)
				add_result(window[i], 1'b1);
			window_count = 0;
			if (step_results.size() == 0)
				add_result(8'h00, 1'b0);
			tail = step_results.pop_back();
			tail.out_chunk_end = 1'b1;
			step_results.push_back(tail);
		end
		if (step_results.size() != 0) begin
			tail = step_results.pop_back();
			tail.run_last = 1'b1;
			step_results.push_back(tail);
		end
	endfunction

	// stop offering and wait until every awaited result is out and the block has settled
	task automatic drain_results();
		body_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain_results();
		cfg_bus.index <= idx;
		cfg_bus.data <= val;
		cfg_bus.valid <= 1'b1;
		do @(posedge clk); while (!cfg_bus.ready);
		apply_reg_write(idx, val);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic ce, input logic typed,
		input result_t want);
		cfg_bus.valid <= 1'b0;
		if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			body_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		body_bus.in_byte <= b;
		body_bus.in_chunk_end <= ce;
		body_bus.valid <= 1'b1;
		do @(posedge clk); while (!body_bus.ready);
		rewrite_byte(b, ce);
		if (typed)
			awaited_results.push_back(want);
		else
			foreach (step_results[i])
				awaited_results.push_back(step_results[i]);
	endtask

	// result side: random stalls, one long hold on request, and the comparison
	initial begin : result_sink
		int      hold_left;
		result_t got;
		result_t want;
		hold_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				got = '{result_bus.out_byte, result_bus.byte_present, result_bus.run_last,
					result_bus.out_chunk_end};
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %02h/%0b/%0b/%0b",
						$time, got.out_byte, got.byte_present, got.run_last,
						got.out_chunk_end);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$display("%0t: out_byte expected %02h, got %02h", $time,
							want.out_byte, got.out_byte);
						mismatches++;
					end
					if (got.byte_present !== want.byte_present) begin
						$display("%0t: byte_present expected %0b, got %0b", $time,
							want.byte_present, got.byte_present);
						mismatches++;
					end
					if (got.run_last !== want.run_last) begin
						$display("%0t: run_last expected %0b, got %0b", $time,
							want.run_last, got.run_last);
						mismatches++;
					end
					if (got.out_chunk_end !== want.out_chunk_end) begin
						$display("%0t: out_chunk_end expected %0b, got %0b", $time,
							want.out_chunk_end, got.out_chunk_end);
						mismatches++;
					end
				end
			end
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold_left = LONG_STALL;
			end else if (hold_left == 0 && sink_idle_pct != 0 &&
				$urandom_range(0, 99) < sink_idle_pct) begin
				hold_left = $urandom_range(1, 8);
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	// ends the run when no transaction moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (body_bus.valid && body_bus.ready) ||
				(result_bus.valid && result_bus.ready) || (cfg_bus.valid && cfg_bus.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		logic [BYTE_W-1:0]          letters [3];
		logic [2*CFG_DATA_W-1:0]    victim_str;
		logic [LEN_W-1:0]           vlen_code;
		logic [LEN_W-1:0]           rlen_code;
		logic [BYTE_W-1:0]          b;
		int                         vlen;
		int                         budget;
		int                         shape;
		int                         run_len;
		arst_n <= 1'b0;
		body_bus.valid <= 1'b0;
		body_bus.in_byte <= '0;
		body_bus.in_chunk_end <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= '0;
		cfg_bus.data <= '0;
		victim_lo = '0;
		victim_hi = '0;
		victim_len_reg = 5'd1;
		repl_lo = '0;
		repl_hi = '0;
		repl_len_reg = '0;
		window_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			if (directed_rows[r].kind == ROW_REG)
				write_reg(directed_rows[r].index, directed_rows[r].value);
			else
				send_byte(directed_rows[r].value[BYTE_W-1:0], directed_rows[r].chunk_end,
					directed_rows[r].typed, directed_rows[r].want);
		end

		for (int phase = 0; phase < N_PHASES; phase++) begin
			// victim drawn from a three-letter alphabet so matches and near misses are common
			for (int k = 0; k < 3; k++)
				letters[k] = BYTE_W'($urandom_range(0, 255));
			for (int k = 0; k < STR_BYTES; k++)
				victim_str[8*k +: 8] = letters[2'($urandom_range(0, 2))];
			if (phase == 0) begin
				vlen_code = 5'd16;
				rlen_code = 5'd0;
			end else if (phase == 1) begin
				vlen_code = 5'd1;
				rlen_code = 5'd16;
			end else if (phase == 2) begin
				vlen_code = LEN_W'($urandom_range(17, 31));
				rlen_code = LEN_W'($urandom_range(17, 31));
			end else begin
				vlen_code = LEN_W'($urandom_range(0, 16));
				rlen_code = LEN_W'($urandom_range(0, 16));
			end
			vlen = (vlen_code == 0) ? 1 : (vlen_code > STR_BYTES) ? STR_BYTES : int'(vlen_code);
			write_reg(CFG_VICTIM_LO, victim_str[CFG_DATA_W-1:0]);
			write_reg(CFG_VICTIM_HI, victim_str[2*CFG_DATA_W-1:CFG_DATA_W]);
			write_reg(CFG_VICTIM_LEN, CFG_DATA_W'(vlen_code));
			write_reg(CFG_REPL_LO, {$urandom, $urandom});
			write_reg(CFG_REPL_HI, {$urandom, $urandom});
			write_reg(CFG_REPL_LEN, CFG_DATA_W'(rlen_code));

			if (phase == N_PHASES - 1) begin
				sender_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: sender_idle_pct = 0;
					1: sender_idle_pct = 15;
					default: sender_idle_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0: sink_idle_pct = 0;
					1: sink_idle_pct = 15;
					default: sink_idle_pct = 40;
				endcase
			end

			budget = ITEMS_PER_PHASE;
			while (budget > 0) begin
				// whole victim, victim prefix, alphabet noise or fully random bytes
				shape = $urandom_range(0, 99);
				if (shape < 50)
					run_len = vlen;
				else if (shape < 70)
					run_len = $urandom_range(1, vlen);
				else
					run_len = $urandom_range(1, 4);
				for (int k = 0; k < run_len && budget > 0; k++) begin
					if (shape < 70)
						b = victim_str[8*k +: 8];
					else if (shape < 90)
						b = letters[2'($urandom_range(0, 2))];
					else
						b = BYTE_W'($urandom_range(0, 255));
					if (shape < 50 && $urandom_range(0, 19) == 0)
						b = BYTE_W'($urandom_range(0, 255));
					send_byte(b, $urandom_range(0, 99) < ((shape < 70) ? 3 : 10), 1'b0, '0);
					budget--;
					if (phase == STALL_PHASE && budget == ITEMS_PER_PHASE - 4)
						long_stall_req = 1'b1;
					if (phase == PAUSE_PHASE && budget == ITEMS_PER_PHASE / 2)
						drain_results();
				end
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/sfr_pkg.sv
src/sfr_in_if.sv
src/sfr_out_if.sv
src/sfr_cfg_if.sv
src/sfr_ctrl.sv
src/sfr_datapath.sv
src/stream_find_and_replace.sv
src/sfr_checker.sv
sim/tb.sv
